// ===== hw/rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// token kind codes, scan modes, keyword matcher states and the token bundle
// passed from the scanner front to the token back end
// ----------------------------------------------------------------------------
package stt_pkg;

  // token kind codes
  localparam logic [3:0] TK_END      = 4'd0;
  localparam logic [3:0] TK_UNKNOWN  = 4'd1;
  localparam logic [3:0] TK_UNCLOSED = 4'd2;
  localparam logic [3:0] TK_IDENT    = 4'd3;
  localparam logic [3:0] TK_COMMENT  = 4'd4;
  localparam logic [3:0] TK_INT      = 4'd5;
  localparam logic [3:0] TK_STR      = 4'd6;
  localparam logic [3:0] TK_PROC     = 4'd7;
  localparam logic [3:0] TK_PRINT    = 4'd8;
  localparam logic [3:0] TK_LPAREN   = 4'd9;
  localparam logic [3:0] TK_RPAREN   = 4'd10;
  localparam logic [3:0] TK_LBRACE   = 4'd11;
  localparam logic [3:0] TK_RBRACE   = 4'd12;
  localparam logic [3:0] TK_SEMI     = 4'd13;
  localparam logic [3:0] TK_BAD      = 4'd14;

  // characters of interest
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HT     = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_P      = 8'h70;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_O      = 8'h6F;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;

  // output field widths and saturation limits
  localparam int unsigned ROW_W   = 20;
  localparam int unsigned COL_W   = 16;
  localparam int unsigned POS_W   = 32;
  localparam logic [ROW_W-1:0] ROW_SAT = '1;
  localparam logic [COL_W-1:0] COL_SAT = '1;

  // most tokens one input byte can cause
  localparam int unsigned MAX_TOKENS = 3;

  // depth of the queue between front and back (power of two)
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_IDENT,
    MODE_INT,
    MODE_STR,
    MODE_ESC
  } mode_t;

  // keyword matcher: progress through "proc" and "print"
  typedef enum logic [2:0] {
    KW_NONE,
    KW_P,
    KW_PR,
    KW_PRO,
    KW_PROC,
    KW_PRI,
    KW_PRIN,
    KW_PRINT
  } kw_t;

  typedef struct packed {
    logic [3:0]       kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] length;
  } tok_t;

  // all tokens caused by one input byte, oldest in slot zero
  typedef struct packed {
    logic [1:0]                 count;
    tok_t [MAX_TOKENS-1:0]      tok;
  } bundle_t;

endpackage

// ===== hw/rtl/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming tokenizer, one text byte per transaction
// takes one byte every cycle while the queue is not full; tokens leave one per
// cycle while out_ready is high, so bytes that cause 2-3 tokens fill the queue
// reset returns the scanner to the start of a new text and empties the queue
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned ROW_BITS    = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        byte_present,
  input  logic        text_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_kind,
  output logic [19:0] token_row,
  output logic [15:0] token_column,
  output logic [31:0] token_start,
  output logic [31:0] token_length,
  output logic        run_last
);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  stt_pkg::bundle_t q_in;
  stt_pkg::bundle_t q_out;

  // scanner front
  stt_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .ROW_BITS    (ROW_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .byte_present (byte_present),
    .text_end     (text_end),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  // queue between front and back
  stt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_out)
  );

  // token back end
  stt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_valid),
    .head_data    (q_out),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_row    (token_row),
    .token_column (token_column),
    .token_start  (token_start),
    .token_length (token_length),
    .run_last     (run_last)
  );

endmodule

// ===== hw/rtl/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front: byte scanner
// classifies one byte per cycle while the queue is not full, tracks position
// and scan mode, and pushes each byte's tokens as one bundle into the queue
// ----------------------------------------------------------------------------
module stt_front #(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned ROW_BITS    = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       text_byte,
  input  logic             byte_present,
  input  logic             text_end,
  input  logic             q_full,
  output logic             q_push,
  output stt_pkg::bundle_t q_data
);

  localparam int unsigned RW = (ROW_BITS > stt_pkg::ROW_W) ? ROW_BITS : stt_pkg::ROW_W;

  // scanner state
  stt_pkg::mode_t               mode;
  logic [OFFSET_BITS-1:0]       byte_offset;
  logic [ROW_BITS-1:0]          line_number;
  logic [OFFSET_BITS-1:0]       line_start;
  logic [OFFSET_BITS-1:0]       pending_start;
  logic [stt_pkg::ROW_W-1:0]    pending_row;
  logic [stt_pkg::COL_W-1:0]    pending_column;
  stt_pkg::kw_t                 kw;
  logic [1:0]                   cont;

  // next values
  stt_pkg::mode_t               mode_next;
  logic [OFFSET_BITS-1:0]       byte_offset_next;
  logic [ROW_BITS-1:0]          line_number_next;
  logic [OFFSET_BITS-1:0]       line_start_next;
  logic [OFFSET_BITS-1:0]       pending_start_next;
  logic [stt_pkg::ROW_W-1:0]    pending_row_next;
  logic [stt_pkg::COL_W-1:0]    pending_column_next;
  stt_pkg::kw_t                 kw_next;
  logic [1:0]                   cont_next;

  // per-byte decode
  logic                         emit_pend;
  logic [3:0]                   pend_kind;
  logic                         do_idle;
  logic                         body;
  logic                         here_tok;
  logic [3:0]                   here_kind;
  logic [2:0]                   here_len;
  logic                         adv;
  logic [2:0]                   adv_sz;
  logic                         str_close;
  logic [2:0]                   sz;
  logic [stt_pkg::ROW_W-1:0]    row_pre;
  logic [stt_pkg::COL_W-1:0]    col_pre;
  logic [1:0]                   n;
  stt_pkg::tok_t [stt_pkg::MAX_TOKENS-1:0] tok;

  logic                         accept;

  // size of a character from its lead byte, zero when bits 7, 5, 4 and 3 are all set
  function automatic logic [2:0] lead_size(input logic [7:0] b);
    if (!b[7])      return 3'd1;
    else if (!b[5]) return 3'd2;
    else if (!b[4]) return 3'd3;
    else if (!b[3]) return 3'd4;
    else            return 3'd0;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == stt_pkg::CH_SPACE || (b >= stt_pkg::CH_HT && b <= stt_pkg::CH_CR);
  endfunction

  function automatic stt_pkg::kw_t kw_step(input stt_pkg::kw_t k, input logic [7:0] b);
    if (k == stt_pkg::KW_P && b == stt_pkg::CH_R)    return stt_pkg::KW_PR;
    if (k == stt_pkg::KW_PR && b == stt_pkg::CH_O)   return stt_pkg::KW_PRO;
    if (k == stt_pkg::KW_PR && b == stt_pkg::CH_I)   return stt_pkg::KW_PRI;
    if (k == stt_pkg::KW_PRO && b == stt_pkg::CH_C)  return stt_pkg::KW_PROC;
    if (k == stt_pkg::KW_PRI && b == stt_pkg::CH_N)  return stt_pkg::KW_PRIN;
    if (k == stt_pkg::KW_PRIN && b == stt_pkg::CH_T) return stt_pkg::KW_PRINT;
    return stt_pkg::KW_NONE;
  endfunction

  function automatic logic [3:0] ident_kind(input stt_pkg::kw_t k);
    if (k == stt_pkg::KW_PROC)  return stt_pkg::TK_PROC;
    if (k == stt_pkg::KW_PRINT) return stt_pkg::TK_PRINT;
    return stt_pkg::TK_IDENT;
  endfunction

  function automatic logic [stt_pkg::ROW_W-1:0] row_sat(input logic [ROW_BITS-1:0] l);
    logic [RW-1:0] e;
    e = RW'(l);
    if (e > RW'(stt_pkg::ROW_SAT)) return stt_pkg::ROW_SAT;
    return stt_pkg::ROW_W'(e);
  endfunction

  function automatic logic [stt_pkg::COL_W-1:0] col_sat(
    input logic [OFFSET_BITS-1:0] off,
    input logic [OFFSET_BITS-1:0] ls
  );
    logic [OFFSET_BITS:0] d;
    d = {1'b0, off - ls} + (OFFSET_BITS+1)'(1);
    if (d > (OFFSET_BITS+1)'(stt_pkg::COL_SAT)) return stt_pkg::COL_SAT;
    return stt_pkg::COL_W'(d);
  endfunction

  function automatic stt_pkg::tok_t mk_tok(
    input logic [3:0]                k,
    input logic [stt_pkg::ROW_W-1:0] r,
    input logic [stt_pkg::COL_W-1:0] c,
    input logic [OFFSET_BITS-1:0]    s,
    input logic [OFFSET_BITS-1:0]    len
  );
    stt_pkg::tok_t t;
    t.kind   = k;
    t.row    = r;
    t.column = c;
    t.start  = stt_pkg::POS_W'(s);
    t.length = stt_pkg::POS_W'(len);
    return t;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign sz       = lead_size(text_byte);
  assign row_pre  = row_sat(line_number);
  assign col_pre  = col_sat(byte_offset, line_start);

  // classify the byte and work out the next state and its tokens
  always_comb begin
    mode_next           = mode;
    byte_offset_next    = byte_offset;
    line_number_next    = line_number;
    line_start_next     = line_start;
    pending_start_next  = pending_start;
    pending_row_next    = pending_row;
    pending_column_next = pending_column;
    kw_next             = kw;
    cont_next           = cont;
    emit_pend           = 1'b0;
    pend_kind           = stt_pkg::TK_UNKNOWN;
    do_idle             = 1'b0;
    body                = 1'b0;
    here_tok            = 1'b0;
    here_kind           = stt_pkg::TK_UNKNOWN;
    here_len            = 3'd1;
    adv                 = 1'b0;
    adv_sz              = 3'd1;
    str_close           = 1'b0;
    n                   = 2'd0;
    tok                 = '0;

    // mode decode
    if (byte_present) begin
      if (cont != 2'd0) begin
        cont_next = cont - 2'd1;
      end else begin
        unique case (mode)
          stt_pkg::MODE_SLASH: begin
            if (text_byte == stt_pkg::CH_SLASH) begin
              mode_next = stt_pkg::MODE_COMMENT;
              adv       = 1'b1;
            end else begin
              emit_pend = 1'b1;
              pend_kind = stt_pkg::TK_UNKNOWN;
              do_idle   = 1'b1;
            end
          end
          stt_pkg::MODE_COMMENT: begin
            if (text_byte == stt_pkg::CH_LF) begin
              emit_pend = 1'b1;
              pend_kind = stt_pkg::TK_COMMENT;
              do_idle   = 1'b1;
            end else begin
              body = 1'b1;
            end
          end
          stt_pkg::MODE_IDENT: begin
            if (is_alpha(text_byte) || is_digit(text_byte)) begin
              kw_next = kw_step(kw, text_byte);
              adv     = 1'b1;
            end else begin
              emit_pend = 1'b1;
              pend_kind = ident_kind(kw);
              do_idle   = 1'b1;
            end
          end
          stt_pkg::MODE_INT: begin
            if (is_digit(text_byte)) begin
              adv = 1'b1;
            end else begin
              emit_pend = 1'b1;
              pend_kind = stt_pkg::TK_INT;
              do_idle   = 1'b1;
            end
          end
          stt_pkg::MODE_STR: begin
            if (text_byte == stt_pkg::CH_LF) begin
              emit_pend = 1'b1;
              pend_kind = stt_pkg::TK_UNCLOSED;
              do_idle   = 1'b1;
            end else begin
              body = 1'b1;
              if (text_byte == stt_pkg::CH_QUOTE) begin
                str_close = 1'b1;
                mode_next = stt_pkg::MODE_IDLE;
              end else if (text_byte == stt_pkg::CH_BSLASH) begin
                mode_next = stt_pkg::MODE_ESC;
              end
            end
          end
          stt_pkg::MODE_ESC: begin
            body      = 1'b1;
            mode_next = stt_pkg::MODE_STR;
          end
          default: begin
            do_idle = 1'b1;
          end
        endcase
      end
    end

    // one character inside a comment or string
    if (body) begin
      adv = 1'b1;
      if (sz == 3'd0) begin
        here_tok  = 1'b1;
        here_kind = stt_pkg::TK_BAD;
        here_len  = 3'd1;
        adv_sz    = 3'd1;
      end else begin
        adv_sz = sz;
      end
      cont_next = 2'(adv_sz - 3'd1);
    end

    // byte seen between tokens
    if (do_idle) begin
      pending_start_next  = byte_offset;
      pending_row_next    = row_pre;
      pending_column_next = col_pre;
      mode_next           = stt_pkg::MODE_IDLE;
      adv                 = 1'b1;
      adv_sz              = 3'd1;
      if (is_space(text_byte)) begin
        mode_next = stt_pkg::MODE_IDLE;
      end else if (text_byte == stt_pkg::CH_SLASH) begin
        mode_next = stt_pkg::MODE_SLASH;
      end else if (text_byte == stt_pkg::CH_LPAREN) begin
        here_tok  = 1'b1;
        here_kind = stt_pkg::TK_LPAREN;
      end else if (text_byte == stt_pkg::CH_RPAREN) begin
        here_tok  = 1'b1;
        here_kind = stt_pkg::TK_RPAREN;
      end else if (text_byte == stt_pkg::CH_LBRACE) begin
        here_tok  = 1'b1;
        here_kind = stt_pkg::TK_LBRACE;
      end else if (text_byte == stt_pkg::CH_RBRACE) begin
        here_tok  = 1'b1;
        here_kind = stt_pkg::TK_RBRACE;
      end else if (text_byte == stt_pkg::CH_SEMI) begin
        here_tok  = 1'b1;
        here_kind = stt_pkg::TK_SEMI;
      end else if (is_alpha(text_byte)) begin
        mode_next = stt_pkg::MODE_IDENT;
        kw_next   = (text_byte == stt_pkg::CH_P) ? stt_pkg::KW_P : stt_pkg::KW_NONE;
      end else if (is_digit(text_byte)) begin
        mode_next = stt_pkg::MODE_INT;
      end else if (text_byte == stt_pkg::CH_QUOTE) begin
        mode_next = stt_pkg::MODE_STR;
      end else if (sz == 3'd0) begin
        here_tok  = 1'b1;
        here_kind = stt_pkg::TK_BAD;
      end else begin
        here_tok  = 1'b1;
        here_kind = stt_pkg::TK_UNKNOWN;
        here_len  = sz;
        adv_sz    = sz;
        cont_next = 2'(sz - 3'd1);
      end
    end

    // tokens closed before this byte moves the position
    if (emit_pend) begin
      tok[n] = mk_tok(pend_kind, pending_row, pending_column, pending_start,
                      byte_offset - pending_start);
      n = n + 2'd1;
    end
    if (here_tok) begin
      tok[n] = mk_tok(here_kind, row_pre, col_pre, byte_offset, OFFSET_BITS'(here_len));
      n = n + 2'd1;
    end

    // advance position, count lines
    if (adv) begin
      byte_offset_next = byte_offset + OFFSET_BITS'(adv_sz);
      if (text_byte == stt_pkg::CH_LF) begin
        if (line_number != {ROW_BITS{1'b1}}) begin
          line_number_next = line_number + ROW_BITS'(1);
        end
        line_start_next = byte_offset_next;
      end
    end

    // closing quote ends the string after its own byte
    if (str_close) begin
      tok[n] = mk_tok(stt_pkg::TK_STR, pending_row_next, pending_column_next,
                      pending_start_next, byte_offset_next - pending_start_next);
      n = n + 2'd1;
    end

    // end of text: close what is open, then the end token, then back to reset
    if (text_end) begin
      case (mode_next) inside
        stt_pkg::MODE_SLASH: begin
          tok[n] = mk_tok(stt_pkg::TK_UNKNOWN, pending_row_next, pending_column_next,
                          pending_start_next, byte_offset_next - pending_start_next);
          n = n + 2'd1;
        end
        stt_pkg::MODE_COMMENT: begin
          tok[n] = mk_tok(stt_pkg::TK_COMMENT, pending_row_next, pending_column_next,
                          pending_start_next, byte_offset_next - pending_start_next);
          n = n + 2'd1;
        end
        stt_pkg::MODE_IDENT: begin
          tok[n] = mk_tok(ident_kind(kw_next), pending_row_next, pending_column_next,
                          pending_start_next, byte_offset_next - pending_start_next);
          n = n + 2'd1;
        end
        stt_pkg::MODE_INT: begin
          tok[n] = mk_tok(stt_pkg::TK_INT, pending_row_next, pending_column_next,
                          pending_start_next, byte_offset_next - pending_start_next);
          n = n + 2'd1;
        end
        stt_pkg::MODE_STR, stt_pkg::MODE_ESC: begin
          tok[n] = mk_tok(stt_pkg::TK_UNCLOSED, pending_row_next, pending_column_next,
                          pending_start_next, byte_offset_next - pending_start_next);
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      tok[n] = mk_tok(stt_pkg::TK_END, row_sat(line_number_next),
                      col_sat(byte_offset_next, line_start_next), byte_offset_next, '0);
      n = n + 2'd1;
      mode_next           = stt_pkg::MODE_IDLE;
      byte_offset_next    = '0;
      line_number_next    = ROW_BITS'(1);
      line_start_next     = '0;
      pending_start_next  = '0;
      pending_row_next    = stt_pkg::ROW_W'(1);
      pending_column_next = stt_pkg::COL_W'(1);
      kw_next             = stt_pkg::KW_NONE;
      cont_next           = 2'd0;
    end
  end

  // queue push of the bundle
  assign q_push       = accept && (n != 2'd0);
  assign q_data.count = n;
  assign q_data.tok   = tok;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= stt_pkg::MODE_IDLE;
      byte_offset    <= '0;
      line_number    <= ROW_BITS'(1);
      line_start     <= '0;
      pending_start  <= '0;
      pending_row    <= stt_pkg::ROW_W'(1);
      pending_column <= stt_pkg::COL_W'(1);
      kw             <= stt_pkg::KW_NONE;
      cont           <= 2'd0;
    end else if (accept) begin
      mode           <= mode_next;
      byte_offset    <= byte_offset_next;
      line_number    <= line_number_next;
      line_start     <= line_start_next;
      pending_start  <= pending_start_next;
      pending_row    <= pending_row_next;
      pending_column <= pending_column_next;
      kw             <= kw_next;
      cont           <= cont_next;
    end
  end

endmodule

// ===== hw/rtl/stt_queue.sv =====
// ----------------------------------------------------------------------------
// stt_queue: bundle queue
// short first-in first-out queue that decouples the scanner from the token
// back end
// ----------------------------------------------------------------------------
module stt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  stt_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output stt_pkg::bundle_t head_data
);

  localparam int unsigned PW = $clog2(stt_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(stt_pkg::QUEUE_DEPTH + 1);

  stt_pkg::bundle_t mem [stt_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full       = (count == CW'(stt_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/stt_back.sv =====
// ----------------------------------------------------------------------------
// stt_back: token back end
// takes bundles from the queue and hands out their tokens one per
// transaction, marking the last token of each bundle
// ----------------------------------------------------------------------------
module stt_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  stt_pkg::bundle_t head_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [3:0]       token_kind,
  output logic [19:0]      token_row,
  output logic [15:0]      token_column,
  output logic [31:0]      token_start,
  output logic [31:0]      token_length,
  output logic             run_last
);

  stt_pkg::bundle_t cur;
  logic             busy;
  logic [1:0]       idx;
  logic             last;
  logic             take;
  stt_pkg::tok_t    sel;

  assign last = (idx == 2'(cur.count - 2'd1));
  assign take = busy && out_ready;
  assign pop  = head_valid && (!busy || (take && last));

  // current bundle and token index
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (take && last) begin
      busy <= 1'b0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  // output selection
  assign sel          = cur.tok[idx];
  assign out_valid    = busy;
  assign token_kind   = sel.kind;
  assign token_row    = sel.row;
  assign token_column = sel.column;
  assign token_start  = sel.start;
  assign token_length = sel.length;
  assign run_last     = last;

endmodule
